### src/fspa_pkg.sv
// Shared types and constants for the fixed slot pool allocator.
// No dependencies; compile first.
`timescale 1ns / 1ps

package fspa_pkg;

    // Pool size; SLOT_W and CNT_W below follow from it.
    localparam int POOL_SLOTS = 16;

    localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CNT_W  = $clog2(POOL_SLOTS + 1);

    // Fixed field widths of the channels.
    localparam int SIZE_W         = 16;
    localparam int RELEASE_SLOT_W = 8;
    localparam int RANGE_W        = RELEASE_SLOT_W + 1;
    localparam int SLOT_FIELD_W   = 4;
    localparam int COUNT_FIELD_W  = 5;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 16;

    localparam logic [SIZE_W-1:0] DEFAULT_WIDTH_RST  = 16'd1920;
    localparam logic [SIZE_W-1:0] DEFAULT_HEIGHT_RST = 16'd1080;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_DEFAULT_WIDTH  = 4'd0;
    localparam cfg_idx_t CFG_DEFAULT_HEIGHT = 4'd1;

    typedef enum logic [0:0] {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_BAD_HANDLE = 2'd2
    } status_t;

    // Request item as held in the input register.
    typedef struct packed {
        op_t                       opcode;
        logic [SIZE_W-1:0]         req_width;
        logic [SIZE_W-1:0]         req_height;
        logic [RELEASE_SLOT_W-1:0] release_slot;
    } req_t;

endpackage

### src/fspa_if.sv
// Channel interfaces for the allocator: request, response, config write.
// Depends on fspa_pkg.
`timescale 1ns / 1ps

interface fspa_req_if;
    import fspa_pkg::*;

    logic                      valid;
    logic                      ready;
    op_t                       opcode;
    logic [SIZE_W-1:0]         req_width;
    logic [SIZE_W-1:0]         req_height;
    logic [RELEASE_SLOT_W-1:0] release_slot;

    modport source (output valid, opcode, req_width, req_height, release_slot,
                    input ready);
    modport sink   (input valid, opcode, req_width, req_height, release_slot,
                    output ready);
endinterface

interface fspa_rsp_if;
    import fspa_pkg::*;

    logic                     valid;
    logic                     ready;
    status_t                  status;
    logic [SLOT_FIELD_W-1:0]  granted_slot;
    logic [SIZE_W-1:0]        granted_width;
    logic [SIZE_W-1:0]        granted_height;
    logic [COUNT_FIELD_W-1:0] active_count;
    logic [COUNT_FIELD_W-1:0] peak_count;

    modport source (output valid, status, granted_slot, granted_width,
                    granted_height, active_count, peak_count,
                    input ready);
    modport sink   (input valid, status, granted_slot, granted_width,
                    granted_height, active_count, peak_count,
                    output ready);
endinterface

interface fspa_cfg_if;
    import fspa_pkg::*;

    logic                  valid;
    logic                  ready;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/fixed_slot_pool_allocator_core.sv
// Top level of the fixed slot pool allocator: input register, allocate/free
// logic, result register. Depends on fspa_pkg and the interfaces in fspa_if.
`timescale 1ns / 1ps

// Usage
//   req : acquire (opcode 0, width/height, zero = default) or release
//         (opcode 1, release_slot). Accepted when req.valid && req.ready.
//   rsp : one item per request: status, granted slot/width/height and the
//         active and peak slot counts after that request.
//   cfg : register writes, always ready. Index 0 default width, index 1
//         default height; other indexes are dropped. Write only when idle.
// Timing
//   A request lands in the input register when accepted and moves to the
//   result register once that is free or being emptied.
//   Throughput is one item per cycle while rsp does not stall, set by the
//   combinational lowest-free priority encoder and count update on the busy bitmap.
// Reset
//   rst_n low empties both registers, frees every slot, zeroes the counts
//   and loads the defaults 1920 x 1080. No clearing pass is needed.
// Backpressure
//   While rsp stalls the result holds and the input register holds; with
//   both full req.ready drops. req.ready follows rsp.ready in the same cycle.

module fixed_slot_pool_allocator_core (
    input  logic              clk,
    input  logic              rst_n,
    fspa_req_if.sink          req,
    fspa_rsp_if.source        rsp,
    fspa_cfg_if.sink          cfg
);
    import fspa_pkg::*;

    // Input stage
    logic  s1_valid_reg;
    logic  s1_valid_next;
    req_t  s1_reg;
    logic  s1_adv;
    logic  req_acc;

    // Allocator state
    logic [POOL_SLOTS-1:0] busy_reg;
    logic [POOL_SLOTS-1:0] busy_next;
    logic [CNT_W-1:0]      active_reg;
    logic [CNT_W-1:0]      active_next;
    logic [CNT_W-1:0]      peak_reg;
    logic [CNT_W-1:0]      peak_next;
    logic [SIZE_W-1:0]     def_width_reg;
    logic [SIZE_W-1:0]     def_height_reg;

    // Result register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic [SLOT_FIELD_W-1:0]  gslot_reg;
    logic [SLOT_FIELD_W-1:0]  gslot_next;
    logic [SIZE_W-1:0]        gwidth_reg;
    logic [SIZE_W-1:0]        gwidth_next;
    logic [SIZE_W-1:0]        gheight_reg;
    logic [SIZE_W-1:0]        gheight_next;

    // Datapath
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              rel_in_range;
    logic [SLOT_W-1:0] rel_idx;
    logic              rel_busy;

    // Handshake: the input register moves on when the result slot is free
    // or being emptied this cycle.
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign req_acc   = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign s1_valid_next  = req_acc || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && !rsp.ready);

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = POOL_SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Release handle check (out of range or already free is a bad handle)
    assign rel_in_range = RANGE_W'(s1_reg.release_slot) < RANGE_W'(POOL_SLOTS);
    assign rel_idx      = SLOT_W'(s1_reg.release_slot);
    assign rel_busy     = rel_in_range && busy_reg[rel_idx];

    always_comb
    begin
        busy_next    = busy_reg;
        active_next  = active_reg;
        peak_next    = peak_reg;
        status_next  = ST_OK;
        gslot_next   = '0;
        gwidth_next  = '0;
        gheight_next = '0;
        if (s1_adv)
        begin
            unique case (s1_reg.opcode)
                OP_ACQUIRE:
                begin
                    if (free_found)
                    begin
                        busy_next[free_idx] = 1'b1;
                        active_next  = active_reg + 1'b1;
                        gslot_next   = SLOT_FIELD_W'(free_idx);
                        gwidth_next  = (s1_reg.req_width != '0) ?
                                       s1_reg.req_width : def_width_reg;
                        gheight_next = (s1_reg.req_height != '0) ?
                                       s1_reg.req_height : def_height_reg;
                        if (active_next > peak_reg)
                        begin
                            peak_next = active_next;
                        end
                    end
                    else
                    begin
                        status_next = ST_EXHAUSTED;
                    end
                end
                OP_RELEASE:
                begin
                    if (rel_busy)
                    begin
                        busy_next[rel_idx] = 1'b0;
                        active_next = active_reg - 1'b1;
                    end
                    else
                    begin
                        status_next = ST_BAD_HANDLE;
                    end
                end
                default:
                begin
                    status_next = ST_BAD_HANDLE;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            busy_reg       <= '0;
            active_reg     <= '0;
            peak_reg       <= '0;
            def_width_reg  <= DEFAULT_WIDTH_RST;
            def_height_reg <= DEFAULT_HEIGHT_RST;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            busy_reg      <= busy_next;
            active_reg    <= active_next;
            peak_reg      <= peak_next;
            if (cfg.valid && cfg.index == CFG_DEFAULT_WIDTH)
            begin
                def_width_reg <= cfg.data;
            end
            if (cfg.valid && cfg.index == CFG_DEFAULT_HEIGHT)
            begin
                def_height_reg <= cfg.data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_reg.opcode       <= req.opcode;
            s1_reg.req_width    <= req.req_width;
            s1_reg.req_height   <= req.req_height;
            s1_reg.release_slot <= req.release_slot;
        end
        if (s1_adv)
        begin
            status_reg  <= status_next;
            gslot_reg   <= gslot_next;
            gwidth_reg  <= gwidth_next;
            gheight_reg <= gheight_next;
        end
    end

    // Counts reported are the ones after the item's own update, which are
    // the live counters until the next item advances.
    logic [COUNT_FIELD_W-1:0] active_hold_reg;
    logic [COUNT_FIELD_W-1:0] peak_hold_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            active_hold_reg <= COUNT_FIELD_W'(active_next);
            peak_hold_reg   <= COUNT_FIELD_W'(peak_next);
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.granted_slot   = gslot_reg;
    assign rsp.granted_width  = gwidth_reg;
    assign rsp.granted_height = gheight_reg;
    assign rsp.active_count   = active_hold_reg;
    assign rsp.peak_count     = peak_hold_reg;

`ifndef SYNTHESIS
    // Active counter tracks the bitmap population.
    a_active_matches_bitmap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(active_reg) == $countones(busy_reg))
        else $error("active count differs from busy bitmap");

    // Peak never below the live count.
    a_peak_ge_active: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= active_reg)
        else $error("peak count below active count");

    // A granted acquire takes exactly one more slot.
    a_acquire_takes_one: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_reg.opcode == OP_ACQUIRE && free_found) |=>
        $countones(busy_reg) == $countones($past(busy_reg)) + 1)
        else $error("acquire did not take exactly one slot");

    // A stalled result blocks the input stage.
    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !s1_adv)
        else $error("input stage advanced over a stalled result");
`endif

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for fixed_slot_pool_allocator_core: a directed table, then
// random acquire/release traffic under several default-size settings.
// Depends on fspa_pkg, the channel interfaces in fspa_if and the core itself.
`timescale 1ns / 1ps

module tb_top;
    import fspa_pkg::*;

    // Indexes outside the two defined registers; writes to them must be dropped.
    localparam cfg_idx_t CFG_SPARE_IDX = 4'd2;
    localparam cfg_idx_t CFG_LAST_IDX  = 4'd15;

    // Room for the slowest correct run, many times over.
    localparam int RUN_LIMIT_NS = 1_000_000;

    // One result item as it appears on rsp.
    typedef struct packed {
        status_t                  status;
        logic [SLOT_FIELD_W-1:0]  granted_slot;
        logic [SIZE_W-1:0]        granted_width;
        logic [SIZE_W-1:0]        granted_height;
        logic [COUNT_FIELD_W-1:0] active_count;
        logic [COUNT_FIELD_W-1:0] peak_count;
    } alloc_rsp_t;

    // A directed table row as handed to the driver; 'pinned' rows carry a typed-in answer.
    typedef struct {
        op_t                       op;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
        logic [RELEASE_SLOT_W-1:0] slot;
        bit                        pinned;
        alloc_rsp_t                want;
    } dir_row_t;

    typedef struct {
        bit         pinned;
        alloc_rsp_t want;
    } pin_t;

    logic clk;
    logic rst_n;

    fspa_req_if req_ch();
    fspa_rsp_if rsp_ch();
    fspa_cfg_if cfg_ch();

    fixed_slot_pool_allocator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Clock, reset, run limit
    // ------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Pool model: busy bitmap, live/peak counts and the two defaults
    // ------------------------------------------------------------------
    logic [POOL_SLOTS-1:0] busy_map;
    int unsigned           slots_in_use;
    int unsigned           slots_peak;
    logic [SIZE_W-1:0]     dflt_width;
    logic [SIZE_W-1:0]     dflt_height;

    dir_row_t   dir_q[$];
    pin_t       pin_q[$];          // one entry per request handed to the driver
    alloc_rsp_t grant_expect_q[$]; // results owed by the core, oldest first
    int unsigned mismatches;
    bit          calm;             // no idling on either side while set

    // Lowest free slot wins; sizes of zero fall back to the current defaults.
    // Failed requests leave the pool untouched and report zero slot/size.
    function automatic alloc_rsp_t predict_grant(op_t op, logic [SIZE_W-1:0] w,
                                                 logic [SIZE_W-1:0] h,
                                                 logic [RELEASE_SLOT_W-1:0] slot);
        alloc_rsp_t r;
        int         free_idx;
        r = '0;
        r.status = ST_OK;
        free_idx = -1;
        if (op == OP_ACQUIRE)
        begin
            for (int i = POOL_SLOTS - 1; i >= 0; i--)
                if (!busy_map[i])
                    free_idx = i;
            if (free_idx < 0)
                r.status = ST_EXHAUSTED;
            else
            begin
                busy_map[free_idx] = 1'b1;
                slots_in_use++;
                if (slots_in_use > slots_peak)
                    slots_peak = slots_in_use;
                r.granted_slot   = SLOT_FIELD_W'(free_idx);
                r.granted_width  = (w != '0) ? w : dflt_width;
                r.granted_height = (h != '0) ? h : dflt_height;
            end
        end
        else if (slot >= POOL_SLOTS)
            r.status = ST_BAD_HANDLE;   // out of range
        else if (!busy_map[slot])
            r.status = ST_BAD_HANDLE;   // double free
        else
        begin
            busy_map[slot] = 1'b0;
            if (slots_in_use > 0)
                slots_in_use--;
        end
        r.active_count = COUNT_FIELD_W'(slots_in_use);
        r.peak_count   = COUNT_FIELD_W'(slots_peak);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Request and config monitor: steps the model at every accepted item
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pin_t       pin;
        alloc_rsp_t pred;
        if (!rst_n)
        begin
            busy_map     <= '0;
            slots_in_use <= 0;
            slots_peak   <= 0;
            dflt_width   <= DEFAULT_WIDTH_RST;
            dflt_height  <= DEFAULT_HEIGHT_RST;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == CFG_DEFAULT_WIDTH)
                    dflt_width = cfg_ch.data;
                else if (cfg_ch.index == CFG_DEFAULT_HEIGHT)
                    dflt_height = cfg_ch.data;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                pin = '{1'b0, '0};
                if (pin_q.size() != 0)
                    pin = pin_q.pop_front();
                pred = predict_grant(req_ch.opcode, req_ch.req_width,
                                     req_ch.req_height, req_ch.release_slot);
                grant_expect_q.push_back(pin.pinned ? pin.want : pred);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: field by field against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        alloc_rsp_t got;
        alloc_rsp_t want;
        string      bad;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{rsp_ch.status, rsp_ch.granted_slot, rsp_ch.granted_width,
                    rsp_ch.granted_height, rsp_ch.active_count, rsp_ch.peak_count};
            if (grant_expect_q.size() == 0)
                report_mismatch($sformatf("unexpected result %h", got));
            else
            begin
                want = grant_expect_q.pop_front();
                bad = "";
                if (got.status !== want.status)                 bad = {bad, " status"};
                if (got.granted_slot !== want.granted_slot)     bad = {bad, " slot"};
                if (got.granted_width !== want.granted_width)   bad = {bad, " width"};
                if (got.granted_height !== want.granted_height) bad = {bad, " height"};
                if (got.active_count !== want.active_count)     bad = {bad, " active"};
                if (got.peak_count !== want.peak_count)         bad = {bad, " peak"};
                if (bad != "")
                    report_mismatch($sformatf("fields:%s got %h want %h", bad, got, want));
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side back-pressure: ~8% stall, none while calm
    // ------------------------------------------------------------------
    always @(posedge clk)
        rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 8);

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic add_row(op_t op, logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                           logic [RELEASE_SLOT_W-1:0] slot, bit pinned, alloc_rsp_t want);
        dir_q.push_back('{op, w, h, slot, pinned, want});
    endtask

    // Leaves valid high after acceptance so back-to-back items need no toggle.
    task automatic send_item(op_t op, logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                             logic [RELEASE_SLOT_W-1:0] slot, bit pinned,
                             alloc_rsp_t want);
        if (!calm && $urandom_range(0, 99) < 8)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        pin_q.push_back('{pinned, want});
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= op;
        req_ch.req_width    <= w;
        req_ch.req_height   <= h;
        req_ch.release_slot <= slot;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Registers change only with the core drained; every item gives a result,
    // so once the last accepted item is queued an empty queue means idle.
    task automatic program_defaults(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                                    bit poke_spare);
        req_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (grant_expect_q.size() != 0)
            @(posedge clk);
        cfg_write(CFG_DEFAULT_WIDTH, w);
        cfg_write(CFG_DEFAULT_HEIGHT, h);
        if (poke_spare)
        begin
            cfg_write(CFG_SPARE_IDX, 16'($urandom));
            cfg_write(CFG_LAST_IDX, 16'($urandom));
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0, 1:    return '0;          // take the default
            2:       return '1;
            3:       return 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Bursts swing between fill-heavy and drain-heavy so the pool runs
    // full (exhaustion) and empty (double free) again and again.
    task automatic run_random(int unsigned count);
        int unsigned acq_pct;
        op_t         op;
        logic [RELEASE_SLOT_W-1:0] slot;
        acq_pct = 75;
        for (int unsigned k = 0; k < count; k++)
        begin
            if (k % 32 == 0)
                acq_pct = $urandom_range(0, 1) ? 80 : 25;
            op = ($urandom_range(0, 99) < acq_pct) ? OP_ACQUIRE : OP_RELEASE;
            if (op == OP_RELEASE && $urandom_range(0, 9) != 0)
                slot = RELEASE_SLOT_W'($urandom_range(0, POOL_SLOTS - 1));
            else
                slot = RELEASE_SLOT_W'($urandom);   // stray or out-of-range handle
            send_item(op, pick_size(), pick_size(), slot, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        calm                = 1'b0;
        mismatches          = 0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_ACQUIRE;
        req_ch.req_width    = '0;
        req_ch.req_height   = '0;
        req_ch.release_slot = '0;
        rsp_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_DEFAULT_WIDTH;
        cfg_ch.data         = '0;

        // Fresh pool: stray releases, then grants at the size extremes.
        add_row(OP_RELEASE, 16'd0, 16'd0, 8'd0, 1'b1,
                '{ST_BAD_HANDLE, 4'd0, 16'd0, 16'd0, 5'd0, 5'd0});
        add_row(OP_RELEASE, 16'hFFFF, 16'hFFFF, 8'd255, 1'b1,
                '{ST_BAD_HANDLE, 4'd0, 16'd0, 16'd0, 5'd0, 5'd0});
        add_row(OP_RELEASE, 16'd0, 16'd0, 8'd16, 1'b1,
                '{ST_BAD_HANDLE, 4'd0, 16'd0, 16'd0, 5'd0, 5'd0});
        add_row(OP_ACQUIRE, 16'd0, 16'd0, 8'd0, 1'b1,
                '{ST_OK, 4'd0, 16'd1920, 16'd1080, 5'd1, 5'd1});
        add_row(OP_ACQUIRE, 16'hFFFF, 16'hFFFF, 8'd0, 1'b1,
                '{ST_OK, 4'd1, 16'hFFFF, 16'hFFFF, 5'd2, 5'd2});
        add_row(OP_ACQUIRE, 16'd1, 16'd1, 8'd0, 1'b1,
                '{ST_OK, 4'd2, 16'd1, 16'd1, 5'd3, 5'd3});
        add_row(OP_ACQUIRE, 16'd0, 16'h8000, 8'd0, 1'b1,
                '{ST_OK, 4'd3, 16'd1920, 16'h8000, 5'd4, 5'd4});
        // Free slot 1, free it again, then the hole is refilled first.
        add_row(OP_RELEASE, 16'hFFFF, 16'hFFFF, 8'd1, 1'b1,
                '{ST_OK, 4'd0, 16'd0, 16'd0, 5'd3, 5'd4});
        add_row(OP_RELEASE, 16'd0, 16'd0, 8'd1, 1'b1,
                '{ST_BAD_HANDLE, 4'd0, 16'd0, 16'd0, 5'd3, 5'd4});
        add_row(OP_ACQUIRE, 16'h1234, 16'd0, 8'd255, 1'b1,
                '{ST_OK, 4'd1, 16'h1234, 16'd1080, 5'd4, 5'd4});
        // Fill the rest of the pool (slots 4..15).
        add_row(OP_ACQUIRE, 16'hA5A5, 16'h5A5A, 8'hAA, 1'b0, '0);
        add_row(OP_ACQUIRE, 16'h5A5A, 16'hA5A5, 8'h55, 1'b0, '0);
        add_row(OP_ACQUIRE, 16'h0000, 16'h7FFF, 8'd0, 1'b0, '0);
        add_row(OP_ACQUIRE, 16'h7FFF, 16'h0000, 8'd0, 1'b0, '0);
        add_row(OP_ACQUIRE, 16'h00FF, 16'hFF00, 8'd0, 1'b0, '0);
        add_row(OP_ACQUIRE, 16'hFF00, 16'h00FF, 8'd0, 1'b0, '0);
        add_row(OP_ACQUIRE, 16'h0F0F, 16'hF0F0, 8'd0, 1'b0, '0);
        add_row(OP_ACQUIRE, 16'hF0F0, 16'h0F0F, 8'd0, 1'b0, '0);
        add_row(OP_ACQUIRE, 16'h3333, 16'hCCCC, 8'd0, 1'b0, '0);
        add_row(OP_ACQUIRE, 16'hCCCC, 16'h3333, 8'd0, 1'b0, '0);
        add_row(OP_ACQUIRE, 16'h0002, 16'h8001, 8'd0, 1'b0, '0);
        add_row(OP_ACQUIRE, 16'h8001, 16'h0002, 8'd0, 1'b0, '0);
        // Full pool: out of slots, then free the top slot twice.
        add_row(OP_ACQUIRE, 16'hFFFF, 16'd0, 8'd0, 1'b1,
                '{ST_EXHAUSTED, 4'd0, 16'd0, 16'd0, 5'd16, 5'd16});
        add_row(OP_RELEASE, 16'd0, 16'd0, 8'd15, 1'b1,
                '{ST_OK, 4'd0, 16'd0, 16'd0, 5'd15, 5'd16});
        add_row(OP_RELEASE, 16'd0, 16'd0, 8'd15, 1'b1,
                '{ST_BAD_HANDLE, 4'd0, 16'd0, 16'd0, 5'd15, 5'd16});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_q[k])
            send_item(dir_q[k].op, dir_q[k].w, dir_q[k].h, dir_q[k].slot,
                      dir_q[k].pinned, dir_q[k].want);

        // Reset defaults, then zero defaults (zero request grants zero),
        // the extremes, a random pair with stray register writes, and back.
        run_random(200);
        program_defaults(16'd0, 16'd0, 1'b0);
        run_random(200);
        program_defaults(16'hFFFF, 16'd1, 1'b1);
        run_random(200);
        program_defaults(16'd1, 16'hFFFF, 1'b0);
        calm = 1'b1;                        // long stretch at full rate
        run_random(200);
        calm = 1'b0;
        program_defaults(16'($urandom), 16'($urandom), 1'b1);
        run_random(200);
        program_defaults(DEFAULT_WIDTH_RST, DEFAULT_HEIGHT_RST, 1'b0);
        run_random(200);

        req_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (grant_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);          // catch any stray extra result

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
